// ----- rtl/crti_pkg.sv -----
// ----------------------------------------------------------------------------
// crti_pkg
// shared constants, calibration roms and types of the range table interpolator
// ----------------------------------------------------------------------------
package crti_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ROW_W         = 12;
  localparam int DIST_W        = 15;
  localparam int BEYOND_RANGE  = 20000;
  localparam int ROW_BASE      = 480;
  localparam int KEY_SHIFT     = -11;
  localparam int LEN_150       = 13;
  localparam int LEN_160       = 11;
  localparam int LEN_170       = 11;
  localparam int N_150 = (LEN_150 < TABLE_ENTRIES) ? LEN_150 : TABLE_ENTRIES;
  localparam int N_160 = (LEN_160 < TABLE_ENTRIES) ? LEN_160 : TABLE_ENTRIES;
  localparam int N_170 = (LEN_170 < TABLE_ENTRIES) ? LEN_170 : TABLE_ENTRIES;

  localparam logic [1:0] TBL_150 = 2'd0;
  localparam logic [1:0] TBL_160 = 2'd1;
  localparam logic [1:0] TBL_170 = 2'd2;

  typedef logic signed [ROW_W-1:0] row_t;
  typedef logic [DIST_W-1:0]       dist_t;

  // per-table lookup summary
  typedef struct packed {
    logic  direct;   // result is d0 with no interpolation
    dist_t d0;
    dist_t d1;
    row_t  num;      // row - k0
    row_t  span;     // k1 - k0
  } seg_t;

  function automatic int raw_key(input logic [1:0] tbl, input int i);
    int k150 [13] = '{495,465,444,427,412,400,390,381,374,367,362,352,346};
    int k160 [11] = '{458,424,400,380,365,342,325,318,312,302,295};
    int k170 [11] = '{478,444,418,397,381,356,337,330,324,315,306};
    case (tbl)
      TBL_150: raw_key = k150[i];
      TBL_160: raw_key = k160[i];
      default: raw_key = k170[i];
    endcase
  endfunction

  function automatic row_t key_at(input logic [1:0] tbl, input int i);
    key_at = row_t'(ROW_BASE - raw_key(tbl, i) + KEY_SHIFT);
  endfunction

  function automatic dist_t dist_at(input logic [1:0] tbl, input int i);
    int d150 [13] = '{300,350,400,450,500,550,600,650,700,750,800,900,1000};
    int d16x [11] = '{300,350,400,450,500,600,700,750,800,900,1000};
    if (tbl == TBL_150) begin
      dist_at = dist_t'(d150[i]);
    end else begin
      dist_at = dist_t'(d16x[i]);
    end
  endfunction

  function automatic int tbl_len(input logic [1:0] tbl);
    case (tbl)
      TBL_150: tbl_len = N_150;
      TBL_160: tbl_len = N_160;
      default: tbl_len = N_170;
    endcase
  endfunction

endpackage

// ----- rtl/camera_range_table_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// camera_range_table_interpolator_top
// range from box bottom row and camera height via calibration roms
// ----------------------------------------------------------------------------
// One transaction in, one out. A new transaction may enter every cycle while the
// output side is ready. The stages are one rom search stage, a multiply stage,
// five divider stages for the segment interpolation, a multiply stage for the
// height blend, a reciprocal multiply stage for the divide by ten, an add stage
// and the output register. The whole pipeline advances only when its last stage
// is empty or taken, so a stall holds everything in place. Heights outside
// 150..170 give valid_res 0, distance 0.
module camera_range_table_interpolator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // box_bottom[10:0], camera_height[18:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // distance[14:0], valid_res[15]
);
  import crti_pkg::*;

  localparam int LAT = 11;
  // ceil(2^22 / 10), exact quotient for every numerator below 699050
  localparam logic [21:0] RECIP_10 = 22'd419431;

  logic [9:0] voff_r;
  logic [LAT-1:0] vld_r;
  logic adv;

  // global enable: hold all stages when the output is stuck
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voff_r <= '0;
      vld_r  <= '0;
    end else begin
      if (cfg_we) voff_r <= cfg_wdata;
      if (adv) vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end
  assign out_tvalid = vld_r[LAT-1];

  // ---- stage 0: corrected row and table choice
  row_t       row;
  logic [7:0] h;
  logic       ok, top, upper;
  assign row   = row_t'($signed(in_tdata[10:0])) + row_t'($signed(voff_r));
  assign h     = in_tdata[18:11];
  assign ok    = h >= 8'd150 && h <= 8'd170;
  assign top   = h == 8'd170;
  assign upper = h >= 8'd160;

  seg_t lo_seg, hi_seg;
  crti_seg u_lo (.clk, .en(adv), .tbl(upper ? TBL_160 : TBL_150), .row,
                 .seg_r(lo_seg));
  crti_seg u_hi (.clk, .en(adv), .tbl(upper ? TBL_170 : TBL_160), .row,
                 .seg_r(hi_seg));

  // side info delay line: ok, top, height fraction
  typedef struct packed {
    logic       ok;
    logic       top;
    logic [3:0] frac;
  } side_t;
  side_t side_r [LAT-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{ok: ok, top: top,
                     frac: 4'(h - (upper ? 8'd160 : 8'd150))};
      for (int i = 1; i < LAT - 1; i++) side_r[i] <= side_r[i-1];
    end
  end

  // ---- stage 1: segment products, sign split for truncation toward zero
  typedef struct packed {
    logic        direct;
    logic [14:0] d0;
    logic        neg;
    logic [19:0] mag;
    logic [9:0]  span;
  } prod_t;
  prod_t pl_r, ph_r;

  function automatic prod_t mk_prod(input seg_t s);
    prod_t p;
    logic signed [16:0] dd;
    logic signed [29:0] pr;
    dd = $signed({2'b0, s.d1}) - $signed({2'b0, s.d0});
    pr = dd * $signed(s.num);
    p.direct = s.direct;
    p.d0     = s.d0;
    p.neg    = pr < 0;
    p.mag    = 20'(pr < 0 ? -pr : pr);
    p.span   = s.direct ? 10'd1 : 10'(s.span);
    return p;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r <= mk_prod(lo_seg);
      ph_r <= mk_prod(hi_seg);
    end
  end

  // ---- stages 2..6: segment divisions
  logic [19:0] ql, qh;
  crti_div u_dl (.clk, .en(adv), .num(pl_r.mag), .den(pl_r.span), .quo_r(ql));
  crti_div u_dh (.clk, .en(adv), .num(ph_r.mag), .den(ph_r.span), .quo_r(qh));

  prod_t pl_d [5], ph_d [5];
  always_ff @(posedge clk) begin
    if (adv) begin
      pl_d[0] <= pl_r;
      ph_d[0] <= ph_r;
      for (int i = 1; i < 5; i++) begin
        pl_d[i] <= pl_d[i-1];
        ph_d[i] <= ph_d[i-1];
      end
    end
  end

  function automatic logic signed [16:0] seg_val(input prod_t p, input logic [19:0] q);
    logic signed [16:0] qs;
    qs = p.neg ? -$signed({1'b0, q[15:0]}) : $signed({1'b0, q[15:0]});
    return p.direct ? $signed({2'b0, p.d0}) : $signed({2'b0, p.d0}) + qs;
  endfunction

  // ---- stage 7: height blend product
  logic signed [16:0] lo_v, hi_v;
  assign lo_v = seg_val(pl_d[4], ql);
  assign hi_v = seg_val(ph_d[4], qh);

  logic signed [16:0] lo_r, hi_r;
  logic               bn_r;
  logic [19:0]        bm_r;
  always_ff @(posedge clk) begin
    logic signed [22:0] bp;
    bp = 23'(hi_v - lo_v) * $signed({19'b0, side_r[6].frac});
    if (adv) begin
      lo_r <= lo_v;
      hi_r <= hi_v;
      bn_r <= bp < 0;
      bm_r <= 20'(bp < 0 ? -bp : bp);
    end
  end

  // ---- stage 8: divide by ten as a reciprocal multiply
  logic [19:0]        qb_r;
  logic signed [16:0] lo2_r, hi2_r;
  logic               bn2_r;
  always_ff @(posedge clk) begin
    logic [41:0] rp;
    rp = {22'b0, bm_r} * {20'b0, RECIP_10};
    if (adv) begin
      qb_r  <= rp[41:22];
      lo2_r <= lo_r;
      hi2_r <= hi_r;
      bn2_r <= bn_r;
    end
  end

  // ---- stages 9..10: combine, select, output register
  logic signed [16:0] rng_r;
  logic [14:0]        res_r;
  logic [15:0]        out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      rng_r <= lo2_r + (bn2_r ? -$signed({1'b0, qb_r[15:0]})
                              : $signed({1'b0, qb_r[15:0]}));
      res_r <= side_r[8].top ? 15'(hi2_r) : 15'(0);
      out_r <= {side_r[9].ok,
                !side_r[9].ok ? 15'd0 : (side_r[9].top ? res_r : 15'(rng_r))};
    end
  end
  assign out_tdata = out_r;

`ifndef ASSERT_OFF
  // a held output does not change while the consumer stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output changed during stall");
  // invalid results carry zero distance
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[15] |-> out_tdata[14:0] == 15'd0)
    else $error("invalid result with nonzero distance");
  // distance never exceeds the beyond-range code
  a_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:0] <= 15'd20000)
    else $error("distance out of range");
`endif

endmodule

// ----- rtl/crti_seg.sv -----
// ----------------------------------------------------------------------------
// crti_seg
// segment search in one calibration rom, registered
// ----------------------------------------------------------------------------
module crti_seg (
  input  logic              clk,
  input  logic              en,
  input  logic [1:0]        tbl,
  input  crti_pkg::row_t    row,
  output crti_pkg::seg_t    seg_r
);
  import crti_pkg::*;

  seg_t seg_nxt;

  always_comb begin
    int   n;
    n = tbl_len(tbl);
    seg_nxt = '0;
    if (row > key_at(tbl, n - 1)) begin
      seg_nxt.direct = 1'b1;
      seg_nxt.d0     = dist_t'(BEYOND_RANGE);
    end else if (row < key_at(tbl, 0)) begin
      seg_nxt.direct = 1'b1;
      seg_nxt.d0     = dist_at(tbl, 0);
    end else begin
      seg_nxt.direct = 1'b1;
      seg_nxt.d0     = dist_at(tbl, n - 1);
      // independent compares per segment, priority to the first
      for (int i = TABLE_ENTRIES - 2; i >= 0; i--) begin
        if (i + 1 < n && key_at(tbl, i) <= row && row <= key_at(tbl, i + 1)) begin
          seg_nxt.direct = 1'b0;
          seg_nxt.d0     = dist_at(tbl, i);
          seg_nxt.d1     = dist_at(tbl, i + 1);
          seg_nxt.num    = row_t'(row - key_at(tbl, i));
          seg_nxt.span   = row_t'(key_at(tbl, i + 1) - key_at(tbl, i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r <= seg_nxt;
    end
  end

endmodule

// ----- rtl/crti_div.sv -----
// ----------------------------------------------------------------------------
// crti_div
// pipelined restoring divider, quotient bits split evenly over the stages, num >= 0, den > 0
// ----------------------------------------------------------------------------
module crti_div (
  input  logic        clk,
  input  logic        en,
  input  logic [19:0] num,
  input  logic [9:0]  den,
  output logic [19:0] quo_r
);
  localparam int NW = 20;
  localparam int ST = 5;
  localparam int BPS = NW / ST;

  logic [NW-1:0] q_r   [ST];
  logic [NW-1:0] rem_r [ST];
  logic [9:0]    den_r [ST];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ST; s++) begin
        logic [NW-1:0] q;
        logic [NW:0]   rm;
        logic [NW-1:0] dn;
        if (s == 0) begin
          q  = num;
          rm = '0;
          dn = NW'(den);
        end else begin
          q  = q_r[s-1];
          rm = {1'b0, rem_r[s-1]};
          dn = NW'(den_r[s-1]);
        end
        for (int b = 0; b < BPS; b++) begin
          rm = {rm[NW-1:0], q[NW-1]};
          q  = {q[NW-2:0], 1'b0};
          if (rm >= {1'b0, dn}) begin
            rm   = rm - {1'b0, dn};
            q[0] = 1'b1;
          end
        end
        q_r[s]   <= q;
        rem_r[s] <= rm[NW-1:0];
        den_r[s] <= dn[9:0];
      end
    end
  end

  assign quo_r = q_r[ST-1];

endmodule
